>>> src/rgbmix_pkg.sv
// ----------------------------------------------------------------------------
// rgbmix_pkg
// Types, register indexes and arithmetic helpers for the RGBCCT color mix.
// ----------------------------------------------------------------------------
package rgbmix_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int QUO_W      = 8;

  localparam logic [CFG_IDX_W-1:0] REG_MAIN_GAINS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CROSS_GAINS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CCT_GAINS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WARM_KELVIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLD_KELVIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_KELVIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL_BAND = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_MODE  = 3'd7;

  localparam logic [13:0] KELVIN_MIN = 14'd1000;
  localparam logic [13:0] KELVIN_MAX = 14'd10000;

  typedef struct packed {
    logic [11:0] pixel_index;
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
    logic [15:0] white_in;
    logic [15:0] warm_in;
    logic [15:0] cold_in;
    logic        use_brightness;
  } pix_in_t;

  typedef struct packed {
    logic [11:0] pixel_index_out;
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic [15:0] warm_out;
    logic [15:0] cold_out;
  } pix_out_t;

  typedef enum logic [1:0] {
    WSEL_NONE,
    WSEL_FULL,
    WSEL_DIV
  } wsel_t;

  typedef struct packed {
    logic [11:0] idx;
    logic [15:0] mr;
    logic [15:0] mg;
    logic [15:0] mb;
    logic [15:0] mw;
    logic [15:0] dw;
    logic [15:0] dc;
    logic [15:0] lo;
    wsel_t       wsel;
    logic        gate;
    logic        korder;
  } mix_ctx_t;

  // v*g + 127, ready for the divide by 255
  function automatic logic [23:0] gmul(logic [15:0] v, logic [7:0] g);
    return 24'(v) * 24'(g) + 24'd127;
  endfunction

  // Exact x/255: low estimate from the 1/256 series, then up to three fixups.
  function automatic logic [16:0] div255(logic [23:0] x);
    logic [16:0] q0;
    logic [24:0] r;
    q0 = 17'(x >> 8) + 17'(x >> 16);
    r  = {1'b0, x} - {q0, 8'b0} + 25'(q0);
    return q0 + 17'(r >= 25'd255) + 17'(r >= 25'd510) + 17'(r >= 25'd765);
  endfunction

  function automatic logic [15:0] sat16(logic [17:0] v);
    return (v > 18'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [13:0] clamp14(logic [13:0] v, logic [13:0] lo, logic [13:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

endpackage

>>> src/rgbmix_div.sv
// ----------------------------------------------------------------------------
// rgbmix_div
// Pipelined restoring divider for an 8-bit quotient, two bits per stage.
// ----------------------------------------------------------------------------
module rgbmix_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 16
) (
  input  logic                         clk,
  input  logic [NUM_W-1:0]             num,
  input  logic [DEN_W-1:0]             den,
  output logic [rgbmix_pkg::QUO_W-1:0] quo
);

  localparam int QW     = rgbmix_pkg::QUO_W;
  localparam int QI_W   = $clog2(QW);
  localparam int BITS   = 2;
  localparam int STAGES = QW / BITS;
  localparam int EXT_W  = NUM_W + QW;

  logic [NUM_W-1:0] rem_r [STAGES];
  logic [DEN_W-1:0] den_r [STAGES];
  logic [QW-1:0]    quo_r [STAGES];

  // Quotient is known to fit QW bits (num < 2^QW * den).
  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [NUM_W-1:0] rem_in, rem_nxt;
    logic [QW-1:0]    quo_in, quo_nxt;
    logic [DEN_W-1:0] den_in;

    if (s == 0) begin : g_first
      assign rem_in = num;
      assign quo_in = '0;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign quo_in = quo_r[s-1];
      assign den_in = den_r[s-1];
    end

    always_comb begin
      logic [EXT_W-1:0] shv;
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      for (int k = 0; k < BITS; k++) begin
        shv = EXT_W'(den_in) << (QW - 1 - s * BITS - k);
        if (EXT_W'(rem_nxt) >= shv) begin
          rem_nxt = rem_nxt - NUM_W'(shv);
          quo_nxt[QI_W'(QW - 1 - s * BITS - k)] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= rem_nxt;
      quo_r[s] <= quo_nxt;
      den_r[s] <= den_in;
    end
  end

  assign quo = quo_r[STAGES-1];

endmodule

>>> src/rgbcct_pixel_color_mix_16bit_unit.sv
// ----------------------------------------------------------------------------
// rgbcct_pixel_color_mix_16bit_unit
// RGBCCT color mix: brightness, 3x3 gain mix, white extraction, CCT split.
// ----------------------------------------------------------------------------
// One pixel beat may enter on every clock (busy is always low); each pixel
// comes out of the output register, marked by out_valid for one cycle.
// The pipeline holds: brightness multiply, gain multiply, divide
// by 255 with sums, neutral band setup, four stages of the shared-shape
// 8-bit quotient dividers (band weight and Kelvin weight in parallel), then
// extraction and the warm/cold split. The output cannot be held off.
module rgbcct_pixel_color_mix_16bit_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  rgbmix_pkg::pix_in_t                  in_data,
  output logic                                 out_valid,
  output rgbmix_pkg::pix_out_t                 out_data,
  input  logic                                 cfg_we,
  input  logic [rgbmix_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [rgbmix_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int DIV_LAT = rgbmix_pkg::QUO_W / 2;

  // configuration
  logic [31:0] main_gains_r;
  logic [47:0] cross_gains_r;
  logic [15:0] cct_gains_r;
  logic [13:0] warm_k_r, cold_k_r, target_k_r;
  logic [15:0] band_r;
  logic [8:0]  bright_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_gains_r  <= 32'hFFFF_FFFF;
      cross_gains_r <= '0;
      cct_gains_r   <= 16'hFFFF;
      warm_k_r      <= 14'd2700;
      cold_k_r      <= 14'd6500;
      target_k_r    <= 14'd4000;
      band_r        <= '0;
      bright_r      <= 9'd255;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rgbmix_pkg::REG_MAIN_GAINS:    main_gains_r  <= cfg_wdata[31:0];
        rgbmix_pkg::REG_CROSS_GAINS:   cross_gains_r <= cfg_wdata[47:0];
        rgbmix_pkg::REG_CCT_GAINS:     cct_gains_r   <= cfg_wdata[15:0];
        rgbmix_pkg::REG_WARM_KELVIN:   warm_k_r      <= cfg_wdata[13:0];
        rgbmix_pkg::REG_COLD_KELVIN:   cold_k_r      <= cfg_wdata[13:0];
        rgbmix_pkg::REG_TARGET_KELVIN: target_k_r    <= cfg_wdata[13:0];
        rgbmix_pkg::REG_NEUTRAL_BAND:  band_r        <= cfg_wdata[15:0];
        rgbmix_pkg::REG_BRIGHT_MODE:   bright_r      <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  logic [7:0] g_r, g_g, g_b, g_w, g_warm, g_cold;
  assign g_r    = main_gains_r[31:24];
  assign g_g    = main_gains_r[23:16];
  assign g_b    = main_gains_r[15:8];
  assign g_w    = main_gains_r[7:0];
  assign g_warm = cct_gains_r[15:8];
  assign g_cold = cct_gains_r[7:0];

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // ---- stage 1: brightness multiply
  logic        v1_r;
  logic [11:0] s1_idx_r;
  logic [24:0] s1_prod_r [4];
  logic [15:0] s1_wwin_r, s1_cwin_r;
  logic [8:0]  bmul;

  assign bmul = in_data.use_brightness ? (9'(bright_r[7:0]) + 9'd1) : 9'd256;

  always_ff @(posedge clk) begin
    s1_idx_r     <= in_data.pixel_index;
    s1_prod_r[0] <= 25'(in_data.red_in) * 25'(bmul);
    s1_prod_r[1] <= 25'(in_data.green_in) * 25'(bmul);
    s1_prod_r[2] <= 25'(in_data.blue_in) * 25'(bmul);
    s1_prod_r[3] <= 25'(in_data.white_in) * 25'(bmul);
    s1_wwin_r    <= in_data.warm_in;
    s1_cwin_r    <= in_data.cold_in;
  end

  // ---- stage 2: gain products
  logic        v2_r;
  logic [11:0] s2_idx_r;
  logic [23:0] s2_p_r [12];
  logic        s2_zero_r;
  logic [15:0] r1, g1, b1, w1;

  assign r1 = s1_prod_r[0][23:8];
  assign g1 = s1_prod_r[1][23:8];
  assign b1 = s1_prod_r[2][23:8];
  assign w1 = s1_prod_r[3][23:8];

  always_ff @(posedge clk) begin
    s2_idx_r   <= s1_idx_r;
    s2_p_r[0]  <= rgbmix_pkg::gmul(r1, g_r);
    s2_p_r[1]  <= rgbmix_pkg::gmul(g1, cross_gains_r[47:40]);
    s2_p_r[2]  <= rgbmix_pkg::gmul(b1, cross_gains_r[39:32]);
    s2_p_r[3]  <= rgbmix_pkg::gmul(g1, g_g);
    s2_p_r[4]  <= rgbmix_pkg::gmul(r1, cross_gains_r[31:24]);
    s2_p_r[5]  <= rgbmix_pkg::gmul(b1, cross_gains_r[23:16]);
    s2_p_r[6]  <= rgbmix_pkg::gmul(b1, g_b);
    s2_p_r[7]  <= rgbmix_pkg::gmul(r1, cross_gains_r[15:8]);
    s2_p_r[8]  <= rgbmix_pkg::gmul(g1, cross_gains_r[7:0]);
    s2_p_r[9]  <= rgbmix_pkg::gmul(w1, g_w);
    s2_p_r[10] <= rgbmix_pkg::gmul(s1_wwin_r, g_warm);
    s2_p_r[11] <= rgbmix_pkg::gmul(s1_cwin_r, g_cold);
    s2_zero_r  <= (s1_wwin_r == '0) && (s1_cwin_r == '0);
  end

  // ---- stage 3: divide by 255, saturating sums
  logic        v3_r;
  logic [11:0] s3_idx_r;
  logic [15:0] s3_mr_r, s3_mg_r, s3_mb_r, s3_mw_r, s3_dw_r, s3_dc_r;
  logic        s3_gate_r;
  logic [16:0] q2 [12];
  logic [15:0] mw2;

  always_comb begin
    for (int i = 0; i < 12; i++) q2[i] = rgbmix_pkg::div255(s2_p_r[i]);
  end
  assign mw2 = q2[9][15:0];

  always_ff @(posedge clk) begin
    s3_idx_r  <= s2_idx_r;
    s3_mr_r   <= rgbmix_pkg::sat16(18'(q2[0]) + 18'(q2[1]) + 18'(q2[2]));
    s3_mg_r   <= rgbmix_pkg::sat16(18'(q2[3]) + 18'(q2[4]) + 18'(q2[5]));
    s3_mb_r   <= rgbmix_pkg::sat16(18'(q2[6]) + 18'(q2[7]) + 18'(q2[8]));
    s3_mw_r   <= mw2;
    s3_dw_r   <= q2[10][15:0];
    s3_dc_r   <= q2[11][15:0];
    s3_gate_r <= bright_r[8] && (mw2 == '0) && s2_zero_r;
  end

  // ---- stage 4: neutral band and Kelvin setup, divider operands
  logic                 v4_r;
  rgbmix_pkg::mix_ctx_t s4_ctx_r;
  logic [23:0]          s4_wnum_r, s4_knum_r;
  logic [15:0]          s4_wden_r, s4_kden_r;

  logic [15:0] lo4, hi4, diff4, thr4, fea4, n4;
  logic [16:0] tf4;
  rgbmix_pkg::wsel_t wsel4;
  logic [13:0] wk4, ck4, tk4;
  logic        kord4;

  always_comb begin
    lo4 = s3_mr_r;
    hi4 = s3_mr_r;
    if (s3_mg_r < lo4) lo4 = s3_mg_r;
    if (s3_mb_r < lo4) lo4 = s3_mb_r;
    if (s3_mg_r > hi4) hi4 = s3_mg_r;
    if (s3_mb_r > hi4) hi4 = s3_mb_r;
    diff4 = hi4 - lo4;
    thr4  = {band_r[15:8], 8'b0} + 16'(band_r[15:8]);
    fea4  = {band_r[7:0], 8'b0} + 16'(band_r[7:0]);
    tf4   = 17'(thr4) + 17'(fea4);
    n4    = 16'(tf4 - 17'(diff4));
    if (diff4 <= thr4)
      wsel4 = rgbmix_pkg::WSEL_FULL;
    else if (fea4 != '0 && 17'(diff4) < tf4)
      wsel4 = rgbmix_pkg::WSEL_DIV;
    else
      wsel4 = rgbmix_pkg::WSEL_NONE;
    wk4   = rgbmix_pkg::clamp14(warm_k_r, rgbmix_pkg::KELVIN_MIN, rgbmix_pkg::KELVIN_MAX);
    ck4   = rgbmix_pkg::clamp14(cold_k_r, rgbmix_pkg::KELVIN_MIN, rgbmix_pkg::KELVIN_MAX);
    kord4 = wk4 >= ck4;
    tk4   = rgbmix_pkg::clamp14(target_k_r, wk4, ck4);
  end

  always_ff @(posedge clk) begin
    s4_ctx_r.idx    <= s3_idx_r;
    s4_ctx_r.mr     <= s3_mr_r;
    s4_ctx_r.mg     <= s3_mg_r;
    s4_ctx_r.mb     <= s3_mb_r;
    s4_ctx_r.mw     <= s3_mw_r;
    s4_ctx_r.dw     <= s3_dw_r;
    s4_ctx_r.dc     <= s3_dc_r;
    s4_ctx_r.lo     <= lo4;
    s4_ctx_r.wsel   <= wsel4;
    s4_ctx_r.gate   <= s3_gate_r;
    s4_ctx_r.korder <= kord4;
    s4_wnum_r       <= {n4, 8'b0} - 24'(n4);
    s4_wden_r       <= (wsel4 == rgbmix_pkg::WSEL_DIV) ? fea4 : 16'd1;
    s4_knum_r       <= kord4 ? 24'd0 : ({2'b0, ck4 - tk4, 8'b0} - 24'(ck4 - tk4));
    s4_kden_r       <= kord4 ? 16'd1 : 16'(ck4 - wk4);
  end

  // ---- divider stages
  logic [rgbmix_pkg::QUO_W-1:0] wq, kq;

  rgbmix_div #(.NUM_W(24), .DEN_W(16)) u_wdiv (
    .clk (clk),
    .num (s4_wnum_r),
    .den (s4_wden_r),
    .quo (wq)
  );

  rgbmix_div #(.NUM_W(24), .DEN_W(16)) u_kdiv (
    .clk (clk),
    .num (s4_knum_r),
    .den (s4_kden_r),
    .quo (kq)
  );

  rgbmix_pkg::mix_ctx_t dly_ctx_r [DIV_LAT];
  logic [DIV_LAT-1:0]   dly_v_r;

  always_ff @(posedge clk) begin
    dly_ctx_r[0] <= s4_ctx_r;
    for (int i = 1; i < DIV_LAT; i++) dly_ctx_r[i] <= dly_ctx_r[i-1];
  end

  // ---- stage 5: band weight, extraction product
  logic                 v5_r;
  rgbmix_pkg::mix_ctx_t s5_ctx_r;
  logic                 s5_ext_r;
  logic [23:0]          s5_exp_r;
  logic [7:0]           s5_wwt_r;
  rgbmix_pkg::mix_ctx_t c5;
  logic [7:0]           wt5;

  assign c5 = dly_ctx_r[DIV_LAT-1];

  always_comb begin
    case (c5.wsel)
      rgbmix_pkg::WSEL_FULL: wt5 = 8'd255;
      rgbmix_pkg::WSEL_DIV:  wt5 = wq;
      default:               wt5 = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    s5_ctx_r <= c5;
    s5_ext_r <= c5.gate && (wt5 != '0);
    s5_exp_r <= 24'(c5.lo) * 24'(wt5);
    s5_wwt_r <= c5.korder ? 8'd255 : kq;
  end

  // ---- stage 6: take extracted part out of RGB
  logic                 v6_r;
  rgbmix_pkg::mix_ctx_t s6_ctx_r;
  logic                 s6_ext_r;
  logic [23:0]          s6_mwp_r;
  logic [7:0]           s6_wwt_r;
  logic [15:0]          ex6;
  rgbmix_pkg::mix_ctx_t c6;

  assign ex6 = 16'(rgbmix_pkg::div255(s5_exp_r));

  always_comb begin
    c6 = s5_ctx_r;
    if (s5_ext_r) begin
      c6.mr = s5_ctx_r.mr - ex6;
      c6.mg = s5_ctx_r.mg - ex6;
      c6.mb = s5_ctx_r.mb - ex6;
    end
  end

  always_ff @(posedge clk) begin
    s6_ctx_r <= c6;
    s6_ext_r <= s5_ext_r;
    s6_mwp_r <= rgbmix_pkg::gmul(ex6, g_w);
    s6_wwt_r <= s5_wwt_r;
  end

  // ---- stage 7: white level, split weights
  logic                 v7_r;
  rgbmix_pkg::mix_ctx_t s7_ctx_r;
  logic [23:0]          s7_swp_r, s7_scp_r;
  logic [15:0]          mw7;

  assign mw7 = s6_ext_r ? 16'(rgbmix_pkg::div255(s6_mwp_r)) : s6_ctx_r.mw;

  always_ff @(posedge clk) begin
    s7_ctx_r <= s6_ctx_r;
    s7_swp_r <= rgbmix_pkg::gmul(mw7, s6_wwt_r);
    s7_scp_r <= rgbmix_pkg::gmul(mw7, 8'd255 - s6_wwt_r);
  end

  // ---- stage 8: warm/cold gain
  logic                 v8_r;
  rgbmix_pkg::mix_ctx_t s8_ctx_r;
  logic [23:0]          s8_awp_r, s8_acp_r;

  always_ff @(posedge clk) begin
    s8_ctx_r <= s7_ctx_r;
    s8_awp_r <= rgbmix_pkg::gmul(16'(rgbmix_pkg::div255(s7_swp_r)), g_warm);
    s8_acp_r <= rgbmix_pkg::gmul(16'(rgbmix_pkg::div255(s7_scp_r)), g_cold);
  end

  // ---- stage 9: output register
  logic                 out_valid_r;
  rgbmix_pkg::pix_out_t out_data_r;

  always_ff @(posedge clk) begin
    out_data_r.pixel_index_out <= s8_ctx_r.idx;
    out_data_r.red_out         <= s8_ctx_r.mr;
    out_data_r.green_out       <= s8_ctx_r.mg;
    out_data_r.blue_out        <= s8_ctx_r.mb;
    out_data_r.warm_out        <= rgbmix_pkg::sat16(18'(s8_ctx_r.dw)
                                  + 18'(rgbmix_pkg::div255(s8_awp_r)));
    out_data_r.cold_out        <= rgbmix_pkg::sat16(18'(s8_ctx_r.dc)
                                  + 18'(rgbmix_pkg::div255(s8_acp_r)));
  end

  // beat valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      dly_v_r     <= '0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= accept;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      dly_v_r     <= {dly_v_r[DIV_LAT-2:0], v4_r};
      v5_r        <= dly_v_r[DIV_LAT-1];
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      v8_r        <= v7_r;
      out_valid_r <= v8_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
